// ----- hdl/strmin_pkg.sv -----
// Shared command codes for the sparse-table range-minimum engine.
`timescale 1ns / 1ps
`default_nettype none

package strmin_pkg;

  // Command class decided by the front end, carried through the queue.
  typedef logic [1:0] op_t;

  localparam op_t OP_APPEND = 2'd0;
  localparam op_t OP_QUERY  = 2'd1;
  localparam op_t OP_ERROR  = 2'd2;

endpackage

`default_nettype wire

// ----- hdl/sparse_table_range_min.sv -----
// Top level of the sparse-table range-minimum engine.
//
//   channel  | ports                              | handshake
//   ---------+------------------------------------+------------------------------
//   command  | kind first value left right        | word taken when start & !busy
//   result   | minimum range_error                | one-cycle done strobe
//
// An append writes level 0, then one higher level RAM write per cycle until the top
// level or a window that would start before index 0; a query makes two reads of one
// level RAM through its single read port; a failed range check needs no table read.
// A two-word queue sits between the front end and the executor, so busy rises
// only when two words wait behind the one being worked on.
// Reset (synchronous) clears the loaded count, the queue and the executor state;
// the table RAMs are not cleared and are only read where appends wrote them.
// The receiver cannot stall: each result is valid for the single done cycle.
`timescale 1ns / 1ps
`default_nettype none

module sparse_table_range_min #(
  parameter int MAX_LENGTH  = 1024,
  parameter int VALUE_WIDTH = 32,
  parameter int LEVELS      = 11
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic                                kind,
  input  wire logic                                first,
  input  wire logic signed [VALUE_WIDTH-1:0]       value,
  input  wire logic        [$clog2(MAX_LENGTH+1)-1:0] left,
  input  wire logic        [$clog2(MAX_LENGTH+1)-1:0] right,
  output logic                                     done,
  output logic signed      [VALUE_WIDTH-1:0]       minimum,
  output logic                                     range_error
);

  localparam int IW      = $clog2(MAX_LENGTH + 1);
  localparam int AW      = $clog2(MAX_LENGTH);
  localparam int LVL_W   = $clog2(LEVELS);
  localparam int Q_DEPTH = 2;
  localparam int Q_WIDTH = $bits(strmin_pkg::op_t) + LVL_W + AW + IW + VALUE_WIDTH;

  logic                   accept;

  // front end -> queue
  logic                   f_push;
  strmin_pkg::op_t        f_op;
  logic [LVL_W-1:0]       f_level;
  logic [AW-1:0]          f_addr;

  // queue -> executor
  logic [Q_WIDTH-1:0]     q_rd_data;
  logic                   q_full;
  logic                   q_empty;
  logic                   q_pop;
  strmin_pkg::op_t        q_op;
  logic [LVL_W-1:0]       q_level;
  logic [AW-1:0]          q_addr;
  logic [IW-1:0]          q_right;
  logic [VALUE_WIDTH-1:0] q_value;

  assign busy   = q_full;
  assign accept = start && !busy;

  strmin_front #(
    .MAX_LENGTH (MAX_LENGTH),
    .LEVELS     (LEVELS)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .kind   (kind),
    .first  (first),
    .left   (left),
    .right  (right),
    .push   (f_push),
    .op     (f_op),
    .level  (f_level),
    .addr   (f_addr)
  );

  strmin_queue #(
    .WIDTH (Q_WIDTH),
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (f_push),
    .push_data ({f_op, f_level, f_addr, right, value}),
    .pop       (q_pop),
    .pop_data  (q_rd_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  assign {q_op, q_level, q_addr, q_right, q_value} = q_rd_data;

  strmin_back #(
    .MAX_LENGTH  (MAX_LENGTH),
    .VALUE_WIDTH (VALUE_WIDTH),
    .LEVELS      (LEVELS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .q_op        (q_op),
    .q_level     (q_level),
    .q_addr      (q_addr),
    .q_right     (q_right),
    .q_value     (q_value),
    .done        (done),
    .minimum     (minimum),
    .range_error (range_error)
  );

  // the front end never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    f_push |-> !q_full)
    else $error("queue push while full");

  // the executor only pops a word that is there
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("queue pop while empty");

  // an error result carries a zero minimum
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (done && range_error) |-> (minimum == '0))
    else $error("error result with nonzero minimum");

  // no result strobe right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !done)
    else $error("done strobe after reset");

endmodule

`default_nettype wire

// ----- hdl/strmin_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module strmin_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- hdl/strmin_queue.sv -----
// Short register FIFO between the command front end and the executor.
`timescale 1ns / 1ps
`default_nettype none

module strmin_queue #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] pop_data,
  output logic                  full,
  output logic                  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [NW-1:0]    count;

  assign full     = (count == NW'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + NW'(1);
        2'b01:   count <= count - NW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hdl/strmin_front.sv -----
// Front end: tracks the loaded count, checks queries and picks the table level.
`timescale 1ns / 1ps
`default_nettype none

module strmin_front #(
  parameter int MAX_LENGTH = 1024,
  parameter int LEVELS     = 11
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              accept,
  input  wire logic                              kind,
  input  wire logic                              first,
  input  wire logic [$clog2(MAX_LENGTH+1)-1:0]   left,
  input  wire logic [$clog2(MAX_LENGTH+1)-1:0]   right,
  output logic                                   push,
  output strmin_pkg::op_t                        op,
  output logic      [$clog2(LEVELS)-1:0]         level,
  output logic      [$clog2(MAX_LENGTH)-1:0]     addr
);

  localparam int IW    = $clog2(MAX_LENGTH + 1);
  localparam int AW    = $clog2(MAX_LENGTH);
  localparam int LVL_W = $clog2(LEVELS);

  logic [IW-1:0] cnt;
  logic [IW-1:0] cnt_next;
  logic [IW-1:0] base;
  logic          full_arr;
  logic          bad_range;
  logic [IW-1:0] diff;

  assign base      = first ? '0 : cnt;
  assign full_arr  = (base >= IW'(MAX_LENGTH));
  assign bad_range = (left >= right) || (right > cnt);
  assign diff      = right - left;

  // floor(log2(diff)), clamped to the top level
  always_comb begin
    int unsigned lv;
    lv = 0;
    for (int i = 0; i < IW; i++) begin
      if (diff[i]) begin
        lv = i;
      end
    end
    if (lv > LEVELS - 1) begin
      lv = LEVELS - 1;
    end
    level = LVL_W'(lv);
  end

  always_comb begin
    cnt_next = cnt;
    push     = 1'b0;
    op       = strmin_pkg::OP_APPEND;
    addr     = base[AW-1:0];
    if (accept) begin
      if (kind) begin
        push = 1'b1;
        op   = bad_range ? strmin_pkg::OP_ERROR : strmin_pkg::OP_QUERY;
        addr = left[AW-1:0];
      end else begin
        // append into a full array is dropped; first still restarts
        cnt_next = full_arr ? base : base + IW'(1);
        push     = !full_arr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/strmin_back.sv -----
// Executor: builds table windows on appends and answers range queries.
`timescale 1ns / 1ps
`default_nettype none

module strmin_back #(
  parameter int MAX_LENGTH  = 1024,
  parameter int VALUE_WIDTH = 32,
  parameter int LEVELS      = 11
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  q_empty,
  output logic                                       q_pop,
  input  wire strmin_pkg::op_t                       q_op,
  input  wire logic        [$clog2(LEVELS)-1:0]      q_level,
  input  wire logic        [$clog2(MAX_LENGTH)-1:0]  q_addr,
  input  wire logic        [$clog2(MAX_LENGTH+1)-1:0] q_right,
  input  wire logic        [VALUE_WIDTH-1:0]         q_value,
  output logic                                       done,
  output logic signed      [VALUE_WIDTH-1:0]         minimum,
  output logic                                       range_error
);

  localparam int IW    = $clog2(MAX_LENGTH + 1);
  localparam int AW    = $clog2(MAX_LENGTH);
  localparam int LVL_W = $clog2(LEVELS);
  localparam int CW    = ((LEVELS > IW) ? LEVELS : IW) + 1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_APP  = 3'd1;
  localparam logic [2:0] ST_LVL  = 3'd2;
  localparam logic [2:0] ST_QA   = 3'd3;
  localparam logic [2:0] ST_QB   = 3'd4;
  localparam logic [2:0] ST_QC   = 3'd5;

  function automatic logic [VALUE_WIDTH-1:0] smin(input logic [VALUE_WIDTH-1:0] a,
                                                  input logic [VALUE_WIDTH-1:0] b);
    return ($signed(a) <= $signed(b)) ? a : b;
  endfunction

  logic [2:0]              state;
  logic [LVL_W-1:0]        lvl_r;
  logic [AW-1:0]           addr_r;
  logic [IW-1:0]           right_r;
  logic [VALUE_WIDTH-1:0]  val_r;
  logic [VALUE_WIDTH-1:0]  cur;
  logic [VALUE_WIDTH-1:0]  a_val;
  logic signed [CW-1:0]    start;
  logic [CW-1:0]           span;
  logic [LVL_W-1:0]        k;
  logic [LVL_W-1:0]        sel;

  logic                    wr_en;
  logic [LVL_W-1:0]        wr_lvl;
  logic [AW-1:0]           wr_addr;
  logic [VALUE_WIDTH-1:0]  wr_data;
  logic [AW-1:0]           rd_addr;
  logic [VALUE_WIDTH-1:0]  rd_all [LEVELS];
  logic [VALUE_WIDTH-1:0]  rd_data;
  logic [VALUE_WIDTH-1:0]  lvl_min;
  logic signed [CW-1:0]    nstart;
  logic [IW-1:0]           b_full;

  // one RAM per table level, shared address buses
  for (genvar i = 0; i < LEVELS; i++) begin : g_level
    strmin_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (MAX_LENGTH)
    ) u_ram (
      .clk   (clk),
      .we    (wr_en && (wr_lvl == LVL_W'(i))),
      .waddr (wr_addr),
      .wdata (wr_data),
      .raddr (rd_addr),
      .rdata (rd_all[i])
    );
  end

  assign rd_data = rd_all[sel];
  assign lvl_min = smin(rd_data, cur);
  assign nstart  = start - $signed(span);
  assign b_full  = right_r - (IW'(1) << lvl_r);
  assign q_pop   = (state == ST_IDLE) && !q_empty;

  always_comb begin
    wr_en   = 1'b0;
    wr_lvl  = '0;
    wr_addr = addr_r;
    wr_data = val_r;
    rd_addr = addr_r;
    case (state)
      ST_APP: begin
        wr_en   = 1'b1;
        rd_addr = addr_r - AW'(1);
      end
      ST_LVL: begin
        wr_en   = 1'b1;
        wr_lvl  = k;
        wr_addr = start[AW-1:0];
        wr_data = lvl_min;
        rd_addr = nstart[AW-1:0];
      end
      ST_QB: begin
        rd_addr = b_full[AW-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      lvl_r   <= q_level;
      addr_r  <= q_addr;
      right_r <= q_right;
      val_r   <= q_value;
    end
    case (state)
      ST_APP: begin
        cur   <= val_r;
        start <= $signed(CW'(addr_r)) - $signed(CW'(1));
        span  <= CW'(2);
        k     <= LVL_W'(1);
        sel   <= '0;
      end
      ST_LVL: begin
        cur   <= lvl_min;
        start <= nstart;
        span  <= span << 1;
        k     <= k + LVL_W'(1);
        sel   <= k;
      end
      ST_QA: begin
        sel <= lvl_r;
      end
      ST_QB: begin
        a_val <= rd_data;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      done        <= 1'b0;
      range_error <= 1'b0;
      minimum     <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (q_pop) begin
            case (q_op)
              strmin_pkg::OP_APPEND: state <= ST_APP;
              strmin_pkg::OP_QUERY:  state <= ST_QA;
              strmin_pkg::OP_ERROR: begin
                done        <= 1'b1;
                range_error <= 1'b1;
                minimum     <= '0;
              end
              default: state <= ST_IDLE;
            endcase
          end
        end
        ST_APP: begin
          state <= (addr_r == '0) ? ST_IDLE : ST_LVL;
        end
        ST_LVL: begin
          if ((k == LVL_W'(LEVELS - 1)) || nstart[CW-1]) begin
            state <= ST_IDLE;
          end
        end
        ST_QA: begin
          state <= ST_QB;
        end
        ST_QB: begin
          state <= ST_QC;
        end
        ST_QC: begin
          done        <= 1'b1;
          range_error <= 1'b0;
          minimum     <= smin(a_val, rd_data);
          state       <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- tb/sparse_table_range_min_tb.sv -----
// Self-checking testbench for the sparse-table range-minimum engine.
`timescale 1ns / 1ps

module sparse_table_range_min_tb;

  localparam int MAX_LEN = 1024;
  localparam int VAL_W   = 32;
  localparam int LEVELS  = 11;
  localparam int IDX_W   = $clog2(MAX_LEN + 1);
  localparam int ADDR_W  = $clog2(MAX_LEN);
  localparam int IDX_MAX = (1 << IDX_W) - 1;

  // Command word kinds as the block decodes the kind port.
  localparam bit KIND_APPEND = 1'b0;
  localparam bit KIND_QUERY  = 1'b1;

  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};

  typedef struct {
    logic signed [VAL_W-1:0] minimum;
    bit                      range_error;
  } range_answer_t;

  // Keeps a flat copy of the loaded array and answers each query by a plain scan,
  // which is an independent check on the block's power-of-two window table.
  class range_min_scoreboard;
    logic signed [VAL_W-1:0] elements [MAX_LEN];
    int unsigned             loaded;
    range_answer_t           answers_due [$];
    int unsigned             mismatches, appends, dropped, queries, bad_ranges, checked;

    task report(string what);
      mismatches++;
      $display("MISMATCH @%0t: %s", $time, what);
    endtask

    function void note_word(bit word_kind, bit word_first,
                            logic signed [VAL_W-1:0] word_value,
                            logic [IDX_W-1:0] word_left, logic [IDX_W-1:0] word_right);
      range_answer_t           ans;
      logic signed [VAL_W-1:0] lowest;
      if (word_kind == KIND_APPEND) begin
        appends++;
        if (word_first) loaded = 0;
        if (loaded >= MAX_LEN) begin
          dropped++;
          return;
        end
        elements[loaded[ADDR_W-1:0]] = word_value;
        loaded++;
        return;
      end
      queries++;
      if (word_left >= word_right || word_right > loaded) begin
        bad_ranges++;
        ans.minimum     = '0;
        ans.range_error = 1'b1;
      end else begin
        lowest = elements[word_left[ADDR_W-1:0]];
        for (int i = word_left + 1; i < word_right; i++)
          if (elements[i[ADDR_W-1:0]] < lowest) lowest = elements[i[ADDR_W-1:0]];
        ans.minimum     = lowest;
        ans.range_error = 1'b0;
      end
      answers_due = {answers_due, ans};
    endfunction

    task check_result(logic signed [VAL_W-1:0] got_min, logic got_err);
      range_answer_t ans;
      if (answers_due.size() == 0) begin
        report($sformatf("result min=%0d err=%b with no query outstanding",
                         got_min, got_err));
        return;
      end
      ans = answers_due.pop_front();
      checked++;
      if (got_err !== ans.range_error)
        report($sformatf("range_error %b, expected %b", got_err, ans.range_error));
      if (got_min !== ans.minimum)
        report($sformatf("minimum %0d, expected %0d", got_min, ans.minimum));
    endtask

    function int unsigned pending();
      return answers_due.size();
    endfunction

    task flush_leftovers();
      if (answers_due.size() != 0)
        report($sformatf("%0d queries never answered", answers_due.size()));
    endtask
  endclass

  logic                    clk = 1'b0;
  logic                    rst;
  logic                    start;
  logic                    busy;
  logic                    kind;
  logic                    first;
  logic signed [VAL_W-1:0] value;
  logic [IDX_W-1:0]        left;
  logic [IDX_W-1:0]        right;
  logic                    done;
  logic signed [VAL_W-1:0] minimum;
  logic                    range_error;

  range_min_scoreboard sb = new;

  int unsigned idle_pct;     // chance in percent of a sender gap before a word
  bit          quiet_tail;   // last stretch of the run: no gaps at all
  int unsigned words_sent;

  sparse_table_range_min #(
    .MAX_LENGTH (MAX_LEN),
    .VALUE_WIDTH(VAL_W),
    .LEVELS     (LEVELS)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .kind       (kind),
    .first      (first),
    .value      (value),
    .left       (left),
    .right      (right),
    .done       (done),
    .minimum    (minimum),
    .range_error(range_error)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Results cannot be held off: every done cycle is one result word, taken at
  // the edge that closes it.
  always @(posedge clk) begin
    if (!rst && done === 1'b1) sb.check_result(minimum, range_error);
  end

  // Presents one command word and holds it until the block takes it
  // (start high and busy low at an edge). Called just after an edge; start is
  // left high so back-to-back words need no second assignment in one step.
  task automatic send_word(bit kind_w, bit first_w, logic signed [VAL_W-1:0] value_w,
                           logic [IDX_W-1:0] left_w, logic [IDX_W-1:0] right_w);
    if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    start <= 1'b1;
    kind  <= kind_w;
    first <= first_w;
    value <= value_w;
    left  <= left_w;
    right <= right_w;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_word(kind_w, first_w, value_w, left_w, right_w);
    words_sent++;
  endtask

  // Sender backs off until every outstanding query has been answered.
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Mix of extremes, a narrow band around zero (ties and duplicates) and full
  // random words.
  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2, 3:    return $urandom_range(0, 16) - 8;
      default: return $urandom;
    endcase
  endfunction

  // Query against the array as the scoreboard sees it after every accepted word.
  // In-range queries pick left < right <= count; the rest are empty or reversed
  // ranges, or run past the loaded count, anywhere in the 11-bit index space.
  task automatic send_query(bit in_range);
    int unsigned n, lo, hi;
    n = sb.loaded;
    if (in_range && n != 0) begin
      lo = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, n - 1);
      hi = ($urandom_range(0, 3) == 0) ? n : $urandom_range(lo + 1, n);
    end else if ($urandom_range(0, 1) == 0) begin
      lo = $urandom_range(0, IDX_MAX);
      hi = $urandom_range(0, lo);
    end else begin
      hi = $urandom_range(n + 1, IDX_MAX);
      lo = $urandom_range(0, IDX_MAX);
    end
    // first and value ride along as noise: a query must ignore them
    send_word(KIND_QUERY, 1'($urandom_range(0, 1)), $urandom,
              lo[IDX_W-1:0], hi[IDX_W-1:0]);
  endtask

  // One array: a first append, more appends with queries sprinkled in. Now and
  // then a stray first flag restarts the array halfway through.
  task automatic run_array(int unsigned len);
    case ($urandom_range(0, 2))
      0:       idle_pct = 0;
      1:       idle_pct = 25;
      default: idle_pct = 60;
    endcase
    if (quiet_tail) idle_pct = 0;
    if (!quiet_tail && $urandom_range(0, 7) == 0) drain_results();
    for (int unsigned i = 0; i < len; i++) begin
      // left and right are ignored by appends, so they carry random bits
      send_word(KIND_APPEND, i == 0 || $urandom_range(0, 99) == 0, pick_value(),
                IDX_W'($urandom), IDX_W'($urandom));
      if ($urandom_range(0, 9) < 4) send_query($urandom_range(0, 3) != 0);
    end
  endtask

  initial begin
    int unsigned target;
    int unsigned spin;

    rst        = 1'b1;
    start      = 1'b0;
    kind       = KIND_APPEND;
    first      = 1'b0;
    value      = '0;
    left       = '0;
    right      = '0;
    idle_pct   = 0;
    quiet_tail = 1'b0;
    words_sent = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // ---- directed part ----
    send_word(KIND_QUERY, 1'b0, '0, IDX_W'(0), IDX_W'(1));   // nothing loaded yet
    send_word(KIND_QUERY, 1'b0, '0, IDX_W'(0), IDX_W'(0));   // empty range
    send_word(KIND_APPEND, 1'b1, VAL_MIN, IDX_W'(IDX_MAX), IDX_W'(IDX_MAX));
    send_word(KIND_APPEND, 1'b0, VAL_MAX, '0, '0);
    send_word(KIND_APPEND, 1'b0, -1, IDX_W'(IDX_MAX), '0);
    send_word(KIND_APPEND, 1'b0, '0, '0, IDX_W'(IDX_MAX));
    send_word(KIND_APPEND, 1'b0, 5, '0, '0);
    send_word(KIND_QUERY, 1'b0, '0, IDX_W'(0), IDX_W'(5));   // two level-2 windows overlap
    send_word(KIND_QUERY, 1'b1, VAL_MAX, IDX_W'(1), IDX_W'(4)); // first/value ignored
    send_word(KIND_QUERY, 1'b0, VAL_MIN, IDX_W'(1), IDX_W'(2)); // single element, largest
    send_word(KIND_QUERY, 1'b0, '0, IDX_W'(4), IDX_W'(5));
    send_word(KIND_QUERY, 1'b0, '0, IDX_W'(3), IDX_W'(5));
    send_word(KIND_QUERY, 1'b0, '0, IDX_W'(0), IDX_W'(6));   // right past loaded count
    send_word(KIND_QUERY, 1'b0, '0, IDX_W'(3), IDX_W'(2));   // reversed
    send_word(KIND_QUERY, 1'b0, '0, IDX_W'(IDX_MAX), IDX_W'(IDX_MAX));
    send_word(KIND_QUERY, 1'b0, '0, IDX_W'(0), IDX_W'(IDX_MAX));
    send_word(KIND_APPEND, 1'b1, 100, '0, '0);               // new array over old entries
    send_word(KIND_QUERY, 1'b0, '0, IDX_W'(0), IDX_W'(2));   // old entries must not count
    send_word(KIND_QUERY, 1'b0, '0, IDX_W'(0), IDX_W'(1));
    send_word(KIND_APPEND, 1'b0, -7, '0, '0);
    send_word(KIND_QUERY, 1'b0, '0, IDX_W'(0), IDX_W'(2));

    // ---- random arrays, mostly short ----
    while (words_sent < 350) run_array($urandom_range(1, 48));

    // ---- one full-length array, then appends past the end ----
    drain_results();
    idle_pct = 25;
    for (int p = 0; p < MAX_LEN; p++) begin
      send_word(KIND_APPEND, p == 0,
                ($urandom_range(0, 31) == 0) ? pick_value() : $urandom,
                IDX_W'($urandom), IDX_W'($urandom));
      if ($urandom_range(0, 15) == 0) send_query(1'b1);
    end
    send_word(KIND_QUERY, 1'b0, '0, IDX_W'(0), IDX_W'(MAX_LEN)); // top level of the table
    send_word(KIND_QUERY, 1'b1, VAL_MIN, IDX_W'(MAX_LEN - 1), IDX_W'(MAX_LEN));
    repeat (3) send_word(KIND_APPEND, 1'b0, VAL_MIN, '0, '0); // dropped: table is full
    send_word(KIND_QUERY, 1'b0, '0, IDX_W'(MAX_LEN - 1), IDX_W'(MAX_LEN));
    send_word(KIND_QUERY, 1'b0, '0, IDX_W'(0), IDX_W'(MAX_LEN));
    send_word(KIND_QUERY, 1'b0, '0, IDX_W'(0), IDX_W'(MAX_LEN + 1));
    send_word(KIND_QUERY, 1'b0, '0, IDX_W'(MAX_LEN), IDX_W'(IDX_MAX));
    repeat (12) send_query(1'b1);

    // ---- last stretch back to back ----
    quiet_tail = 1'b1;
    target     = words_sent + 150;
    while (words_sent < target) run_array($urandom_range(1, 40));

    start <= 1'b0;
    spin = 0;
    do begin
      @(posedge clk);
      spin++;
    end while (sb.pending() != 0 && spin < 2000);
    // appends still in the executor produce nothing; give them time anyway
    repeat (40) @(posedge clk);
    sb.flush_leftovers();

    $display("Sent %0d words: %0d appends (%0d dropped on a full table),",
             words_sent, sb.appends, sb.dropped);
    $display("%0d queries (%0d out of range), results checked: %0d, miscompares: %0d",
             sb.queries, sb.bad_ranges, sb.checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("Timeout: block stopped responding");
    $display("Mismatches found");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/strmin_pkg.sv
hdl/strmin_ram.sv
hdl/strmin_queue.sv
hdl/strmin_front.sv
hdl/strmin_back.sv
hdl/sparse_table_range_min.sv
tb/sparse_table_range_min_tb.sv
